// ===== rtl/bpcr_pkg.sv =====
// shared types and constants for the clock page replacer
// no dependencies
`timescale 1ns / 1ps
package bpcr_pkg;
	localparam int FRAMES_DEF = 16;
	localparam logic [1:0] OP_GET = 2'd0;
	localparam logic [1:0] OP_DIRTY = 2'd1;
	localparam logic [1:0] OP_PIN = 2'd2;
	localparam logic [1:0] OP_UNPIN = 2'd3;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [1:0] ST_NO_VICTIM = 2'd2;
	localparam logic [1:0] ST_BAD_FRAME = 2'd3;

	typedef struct packed {
		logic [15:0] tag;
		logic [31:0] blk;
	} page_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  frame;
		logic        hit;
		logic        load;
		logic        wb;
		logic [15:0] vtag;
		logic [31:0] vblk;
	} result_t;
endpackage

// ===== rtl/buffer_pool_clock_replacer.sv =====
// top level of the clock page replacer: sequencer over tag and metadata memories
// uses bpcr_pkg, bpcr_tag_mem, bpcr_meta_mem
`timescale 1ns / 1ps
//  channel | direction | fields
//  in      | input     | opcode file_tag block_number frame_index
//  out     | output    | status frame_out hit load_needed writeback_needed victim_*
// frame ops read metadata in S_OPRD, write it in S_OPWR; get page scans frames
// one read a cycle until a hit or all are read; a miss with a full pool sweeps
// up to 2*FRAMES frames, one per cycle, set by each memory's single read port.
// reset clears valid bits and hand; metadata of a free frame is rewritten on load.
// the result sits in an output register; a new beat is taken once it is taken.
module buffer_pool_clock_replacer #(
	parameter int FRAMES = bpcr_pkg::FRAMES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [15:0] file_tag,
	input  logic [31:0] block_number,
	input  logic [3:0]  frame_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [3:0]  frame_out,
	output logic        hit,
	output logic        load_needed,
	output logic        writeback_needed,
	output logic [15:0] victim_file_tag,
	output logic [31:0] victim_block
);
	localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CW = $clog2(2 * FRAMES + 1);
	localparam logic [AW-1:0] LAST = AW'(FRAMES - 1);

	typedef enum logic [2:0] {S_IDLE, S_OPRD, S_OPWR, S_SCAN, S_SWEEP, S_LOAD, S_DONE}
		state_t;

	state_t            state_q;
	logic [FRAMES-1:0] valid_q;
	logic [AW-1:0]     hand_q, addr_q, slot_q;
	logic [CW-1:0]     cnt_q;
	logic              free_found_q, wb_q;
	logic [1:0]        op_q;
	bpcr_pkg::page_t   req_q;
	logic [3:0]        fidx_q;
	bpcr_pkg::result_t res_q;

	logic [AW-1:0]   tag_raddr, meta_raddr, meta_waddr, tag_waddr;
	bpcr_pkg::page_t tag_rd, tag_wd;
	logic [9:0]      meta_rd, meta_wd;
	logic            tag_we, meta_we;
	logic [7:0]      pins;
	logic            dirty, refd;

	assign pins = meta_rd[9:2];
	assign dirty = meta_rd[1];
	assign refd = meta_rd[0];

	bpcr_tag_mem #(.FRAMES(FRAMES), .AW(AW)) u_tag (
		.clk, .raddr(tag_raddr), .rdata(tag_rd),
		.we(tag_we), .waddr(tag_waddr), .wdata(tag_wd));
	bpcr_meta_mem #(.FRAMES(FRAMES), .AW(AW)) u_meta (
		.clk, .raddr(meta_raddr), .rdata(meta_rd),
		.we(meta_we), .waddr(meta_waddr), .wdata(meta_wd));

	logic          fin_range, is_get, bad_f;
	logic [AW-1:0] fidx_a, start_a, hand_nx, addr_nx;
	assign fin_range = ({28'd0, frame_index} < 32'(FRAMES));
	assign fidx_a = AW'(frame_index);
	assign is_get = (opcode == bpcr_pkg::OP_GET);
	assign bad_f = !fin_range || !valid_q[fidx_a];
	assign start_a = (!is_get && fin_range) ? fidx_a : '0;
	assign hand_nx = (hand_q == LAST) ? '0 : hand_q + 1'b1;
	assign addr_nx = (addr_q == LAST) ? '0 : addr_q + 1'b1;

	always_comb begin
		tag_raddr = '0;
		meta_raddr = '0;
		tag_we = 1'b0;
		tag_waddr = slot_q;
		tag_wd = req_q;
		meta_we = 1'b0;
		meta_waddr = addr_q;
		meta_wd = meta_rd;
		case (state_q)
			S_IDLE: begin
				tag_raddr = start_a;
				meta_raddr = start_a;
			end
			S_OPRD: begin
				meta_raddr = addr_q;
			end
			S_OPWR: begin
				meta_raddr = addr_q;
				if (valid_q[addr_q] && fidx_q == 4'(addr_q)) begin
					case (op_q)
						bpcr_pkg::OP_DIRTY: begin
							meta_we = 1'b1;
							meta_wd = {pins, 1'b1, refd};
						end
						bpcr_pkg::OP_PIN: begin
							meta_we = (pins != 8'hff);
							meta_wd = {pins + 8'd1, dirty, refd};
						end
						bpcr_pkg::OP_UNPIN: begin
							meta_we = (pins != 8'd0);
							meta_wd = {pins - 8'd1, dirty, refd};
						end
						default: meta_we = 1'b0;
					endcase
				end
			end
			S_SCAN: begin
				tag_raddr = addr_nx;
				meta_raddr = addr_nx;
				if (valid_q[addr_q] && tag_rd == req_q) begin
					meta_we = 1'b1;
					meta_wd = {pins, dirty, 1'b1};
				end
				if (cnt_q == CW'(FRAMES - 1) && !free_found_q
					&& !(valid_q[addr_q] && tag_rd == req_q)) begin
					tag_raddr = hand_q;
					meta_raddr = hand_q;
				end
			end
			S_SWEEP: begin
				tag_raddr = hand_nx;
				meta_raddr = hand_nx;
				meta_waddr = hand_q;
				if (refd) begin
					meta_we = 1'b1;
					meta_wd = {pins, dirty, 1'b0};
				end
			end
			S_LOAD: begin
				tag_we = 1'b1;
				meta_we = 1'b1;
				meta_waddr = slot_q;
				meta_wd = {8'd1, 1'b0, 1'b1};
			end
			default: ;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_DONE);
	assign status = res_q.status;
	assign frame_out = res_q.frame;
	assign hit = res_q.hit;
	assign load_needed = res_q.load;
	assign writeback_needed = res_q.wb;
	assign victim_file_tag = res_q.vtag;
	assign victim_block = res_q.vblk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			hand_q <= '0;
			cnt_q <= '0;
			free_found_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q <= opcode;
						req_q <= '{tag: file_tag, blk: block_number};
						fidx_q <= frame_index;
						addr_q <= start_a;
						cnt_q <= '0;
						free_found_q <= 1'b0;
						wb_q <= 1'b0;
						res_q <= {(!is_get && bad_f) ? bpcr_pkg::ST_BAD_FRAME
							: bpcr_pkg::ST_OK, is_get ? 4'd0 : frame_index,
							3'd0, 16'd0, 32'd0};
						if (is_get)
							state_q <= S_SCAN;
						else if (bad_f)
							state_q <= S_DONE;
						else
							state_q <= S_OPRD;
					end
				end
				S_OPRD: state_q <= S_OPWR;
				S_OPWR: begin
					if (op_q == bpcr_pkg::OP_UNPIN && pins == 8'd0)
						res_q.status <= bpcr_pkg::ST_UNDERFLOW;
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (valid_q[addr_q] && tag_rd == req_q) begin
						res_q.hit <= 1'b1;
						res_q.frame <= 4'(addr_q);
						state_q <= S_DONE;
					end else begin
						if (!valid_q[addr_q] && !free_found_q) begin
							free_found_q <= 1'b1;
							slot_q <= addr_q;
						end
						addr_q <= addr_nx;
						if (cnt_q == CW'(FRAMES - 1)) begin
							cnt_q <= '0;
							if (free_found_q || !valid_q[addr_q])
								state_q <= S_LOAD;
							else
								state_q <= S_SWEEP;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				S_SWEEP: begin
					if (!refd && pins == 8'd0) begin
						slot_q <= hand_q;
						wb_q <= dirty;
						if (dirty) begin
							res_q.vtag <= tag_rd.tag;
							res_q.vblk <= tag_rd.blk;
						end
						state_q <= S_LOAD;
					end else begin
						hand_q <= hand_nx;
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == CW'(2 * FRAMES - 1)) begin
							res_q.status <= bpcr_pkg::ST_NO_VICTIM;
							state_q <= S_DONE;
						end
					end
				end
				S_LOAD: begin
					valid_q[slot_q] <= 1'b1;
					res_q.frame <= 4'(slot_q);
					res_q.load <= 1'b1;
					res_q.wb <= wb_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_stall)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/bpcr_tag_mem.sv =====
// page tag memory, one synchronous read port and one write port
// uses bpcr_pkg
`timescale 1ns / 1ps
module bpcr_tag_mem #(
	parameter int FRAMES = bpcr_pkg::FRAMES_DEF,
	parameter int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
	input  logic             clk,
	input  logic [AW-1:0]    raddr,
	output bpcr_pkg::page_t  rdata,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  bpcr_pkg::page_t  wdata
);
	bpcr_pkg::page_t mem [FRAMES];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/bpcr_meta_mem.sv =====
// frame metadata memory: pin count, dirty and reference bits
// uses bpcr_pkg only for defaults
`timescale 1ns / 1ps
module bpcr_meta_mem #(
	parameter int FRAMES = bpcr_pkg::FRAMES_DEF,
	parameter int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
	input  logic          clk,
	input  logic [AW-1:0] raddr,
	output logic [9:0]    rdata,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [9:0]    wdata
);
	logic [9:0] mem [FRAMES];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/bpcr_checker.sv =====
// port-level checks for the clock page replacer, bound to the top level
// uses bpcr_pkg and the top level ports
`timescale 1ns / 1ps
module bpcr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic        hit,
	input logic        load_needed,
	input logic        writeback_needed
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("result beat dropped while stalled");
	a_hit_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && load_needed))
		else $error("hit and load together");
	a_wb: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && writeback_needed |-> load_needed)
		else $error("write-back without load");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");
	a_nv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == bpcr_pkg::ST_NO_VICTIM |-> !hit && !load_needed)
		else $error("no victim with a frame");
endmodule

bind buffer_pool_clock_replacer bpcr_checker u_bpcr_checker (
	.clk, .arst_n, .in_stall, .out_valid, .out_stall,
	.status, .hit, .load_needed, .writeback_needed);
